[rtl/ecrt_pkg.sv]
// Shared types and constants for the eight-channel rate timer.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ecrt_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int COUNT_W    = 40;
  localparam int IVAL_W     = 32;
  localparam int RATE_W     = 16;
  localparam int DIV_STEPS  = 32;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 24;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_PENDING = 2'd0,
    REG_ENABLE  = 2'd1,
    REG_RATE_LO = 2'd2,
    REG_RATE_HI = 2'd3
  } reg_addr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_step;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_div;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

[rtl/ecrt_ctrl.sv]
// Controller state machine for the rate timer.
// Depends on ecrt_pkg; drives cmd_t to the datapath, reads status_t.
`timescale 1ns / 1ps
`default_nettype none
module ecrt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic             m_tready,
  input  wire ecrt_pkg::status_t status,
  output ecrt_pkg::cmd_t        cmd,
  output ecrt_pkg::state_t      state
);
  import ecrt_pkg::*;

  state_t state_next;
  logic   accept;

  // ready only when idle and the output register is free or draining
  assign s_tready = (state == ST_IDLE) && (!status.out_busy || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && status.needs_div) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.capture  = accept;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_LOAD: cmd.load     = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/ecrt_datapath.sv]
// Datapath: byte registers, timer counters, restoring divider, result register.
// Depends on ecrt_pkg; commanded by ecrt_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module ecrt_datapath #(
  parameter int CLOCK_HZ   = 8000000,
  parameter int NUM_TIMERS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ecrt_pkg::IN_W-1:0]   s_tdata,
  input  wire logic                        m_tready,
  input  wire ecrt_pkg::cmd_t              cmd,
  output ecrt_pkg::status_t                status,
  output logic                             m_tvalid,
  output logic [ecrt_pkg::OUT_W-1:0]       m_tdata
);
  import ecrt_pkg::*;

  localparam longint TOTAL64 = 64'(60) * 64'(CLOCK_HZ);
  localparam logic [IVAL_W-1:0] TOTAL = TOTAL64[IVAL_W-1:0];
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // input fields
  action_t           in_action;
  reg_addr_t         in_addr;
  logic [7:0]        in_data;
  logic [31:0]       in_cycles;
  assign in_action = action_t'(s_tdata[1:0]);
  assign in_addr   = reg_addr_t'(s_tdata[3:2]);
  assign in_data   = s_tdata[11:4];
  assign in_cycles = s_tdata[43:12];

  logic [7:0]          pending;
  logic [7:0]          enable;
  logic [7:0]          rate_lo;
  logic [7:0]          rate_hi;
  logic [IVAL_W-1:0]   ival [SLOT_COUNT];
  logic [COUNT_W-1:0]  cnt  [SLOT_COUNT];

  logic [7:0]          active_mask;
  logic [7:0]          rising;
  logic [7:0]          rising_q;
  logic [7:0]          enable_q;

  // divider
  logic [IVAL_W-1:0]   quo;
  logic [RATE_W:0]     rem;
  logic [RATE_W-1:0]   divisor;
  logic [4:0]          step;
  logic [RATE_W:0]     trial;

  // tick results
  logic [COUNT_W-1:0]  cnt_tick [SLOT_COUNT];
  logic [7:0]          fire;
  logic [7:0]          pending_next;
  logic [7:0]          read_next;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      active_mask[i] = (i < NUM_TIMERS);
    end
  end

  assign rising = in_data & ~enable & active_mask;

  assign status.needs_div = (in_action == ACT_WRITE) && (in_addr == REG_ENABLE) &&
                            (rising != 8'd0);
  assign status.div_last  = (step == 5'(DIV_STEPS - 1));
  assign status.out_busy  = m_tvalid;

  // per-timer tick: saturating add, then one subtract when due
  always_comb begin
    logic [COUNT_W:0] sum;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      sum = {1'b0, cnt[i]} + {{(COUNT_W + 1 - 32){1'b0}}, in_cycles};
      cnt_tick[i] = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      fire[i] = active_mask[i] && enable[i] &&
                (cnt_tick[i] >= {{(COUNT_W - IVAL_W){1'b0}}, ival[i]});
      if (fire[i]) cnt_tick[i] = cnt_tick[i] - {{(COUNT_W - IVAL_W){1'b0}}, ival[i]};
    end
  end

  // pending and read data for an item taken straight through
  always_comb begin
    pending_next = pending;
    read_next    = 8'd0;
    case (in_action)
      ACT_READ: begin
        unique case (in_addr)
          REG_PENDING: read_next = pending;
          REG_ENABLE:  read_next = enable;
          REG_RATE_LO: read_next = rate_lo;
          REG_RATE_HI: read_next = rate_hi;
          default:     read_next = 8'd0;
        endcase
      end
      ACT_WRITE: begin
        if (in_addr == REG_PENDING) pending_next = pending & ~in_data;
      end
      ACT_TICK: pending_next = pending | fire;
      default: pending_next = pending;
    endcase
  end

  assign trial = {rem[RATE_W-1:0], quo[IVAL_W-1]};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 8'd0;
      enable  <= 8'd0;
      rate_lo <= 8'd1;
      rate_hi <= 8'd0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        ival[i] <= TOTAL;
        cnt[i]  <= '0;
      end
    end else if (cmd.capture) begin
      pending <= pending_next;
      if (in_action == ACT_WRITE) begin
        unique case (in_addr)
          REG_ENABLE:  if (rising == 8'd0) enable <= in_data;
          REG_RATE_LO: rate_lo <= in_data;
          REG_RATE_HI: rate_hi <= in_data;
          default: ;
        endcase
      end
      if (in_action == ACT_TICK) begin
        for (int i = 0; i < SLOT_COUNT; i++) cnt[i] <= cnt_tick[i];
      end
    end else if (cmd.load) begin
      enable <= enable_q;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (rising_q[i]) begin
          ival[i] <= quo;
          cnt[i]  <= '0;
        end
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      quo      <= TOTAL;
      rem      <= '0;
      step     <= 5'd0;
      divisor  <= ({rate_hi, rate_lo} == 16'd0) ? 16'd1 : {rate_hi, rate_lo};
      rising_q <= rising;
      enable_q <= in_data;
    end else if (cmd.div_step) begin
      step <= step + 5'd1;
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        quo <= {quo[IVAL_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[IVAL_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((cmd.capture && !status.needs_div) || cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && !status.needs_div) begin
      m_tdata <= {7'd0, pending_next, (pending_next != 8'd0), read_next};
    end else if (cmd.load) begin
      m_tdata <= {7'd0, pending, (pending != 8'd0), 8'd0};
    end
  end

endmodule
`default_nettype wire

[rtl/eight_channel_rate_timer.sv]
// Top level of the eight-channel rate timer: controller plus datapath.
// Depends on ecrt_pkg, ecrt_ctrl and ecrt_datapath.
//
//  channel  dir  width  fields (lsb first)
//  s_*      in   48     action[1:0] address[3:2] write_data[11:4] cycles[43:12]
//  m_*      out  24     read_data[7:0] irq[8] pending_mask[16:9]
//
// Reads, plain writes and ticks: the result is registered in the cycle after acceptance.
// An enable write that turns a timer on runs the 32-step restoring divider
// for 60*CLOCK_HZ/rate, then the load state.
// Reset is synchronous; counters clear and intervals take 60*CLOCK_HZ.
// A held result stalls input only until the result register drains.
`timescale 1ns / 1ps
`default_nettype none
module eight_channel_rate_timer #(
  parameter int CLOCK_HZ   = 8000000,
  parameter int NUM_TIMERS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // action, address, write_data, cycles
  input  wire logic [ecrt_pkg::IN_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // read_data, irq, pending_mask
  output logic [ecrt_pkg::OUT_W-1:0]      m_tdata
);
  import ecrt_pkg::*;

  cmd_t    cmd;
  status_t status;
  state_t  state;

  ecrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  ecrt_datapath #(
    .CLOCK_HZ   (CLOCK_HZ),
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

  // no input taken while the divider runs
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !s_tready)
    else $error("input accepted during division");

  // irq follows the pending mask in every result
  a_irq_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] == (m_tdata[16:9] != 8'd0)))
    else $error("irq disagrees with pending mask");

  // the last divide step is always followed by a load
  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && status.div_last) |=> cmd.load)
    else $error("division finished without load");

endmodule
`default_nettype wire

[sim/tb_eight_channel_rate_timer.sv]
// Self-checking testbench for the eight-channel rate timer.
// Drives register reads, writes and ticks over the input stream and checks every result
// against an in-bench model of the timers. Depends on ecrt_pkg and eight_channel_rate_timer.
`timescale 1ns / 1ps
`default_nettype none
module tb_eight_channel_rate_timer;
  import ecrt_pkg::*;

  localparam int HZ     = 8000000;
  localparam int NTIM   = 8;
  localparam longint CMAX = (64'd1 << 40) - 1;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] pending_mask;
    logic       irq;
    logic [7:0] read_data;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;

  eight_channel_rate_timer #(.CLOCK_HZ(HZ), .NUM_TIMERS(NTIM)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // timer state mirrored in the bench
  logic [7:0]  pend, ena, rlo, rhi;
  logic [31:0] ival [NTIM];
  logic [39:0] cnt  [NTIM];

  result_t expected_q[$];
  int  errors = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  bit  calm = 0;        // no idling on either side
  int  hold_off = 0;    // receiver pause in cycles
  longint cyc = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] interval_of(logic [15:0] rate);
    longint r;
    r = (rate == 0) ? 1 : rate;
    return 32'((longint'(60) * HZ) / r);
  endfunction

  // apply one item to the model and queue its expected result
  function automatic void predict(action_t act, reg_addr_t addr, logic [7:0] wd,
                                  logic [31:0] ncyc);
    result_t r;
    logic [7:0] rising;
    longint c;
    r.read_data = 0;
    case (act)
      ACT_READ: begin
        case (addr)
          REG_PENDING: r.read_data = pend;
          REG_ENABLE:  r.read_data = ena;
          REG_RATE_LO: r.read_data = rlo;
          default:     r.read_data = rhi;
        endcase
      end
      ACT_WRITE: begin
        case (addr)
          REG_PENDING: pend &= ~wd;
          REG_ENABLE: begin
            rising = wd & ~ena;
            for (int i = 0; i < NTIM; i++)
              if (rising[i]) begin
                ival[i] = interval_of({rhi, rlo});
                cnt[i]  = 0;
              end
            ena = wd;
          end
          REG_RATE_LO: rlo = wd;
          default:     rhi = wd;
        endcase
      end
      ACT_TICK: begin
        for (int i = 0; i < NTIM; i++) begin
          c = longint'(cnt[i]) + longint'(ncyc);
          if (c > CMAX) c = CMAX;
          if (ena[i] && c >= longint'(ival[i])) begin
            c -= longint'(ival[i]);
            pend[i] = 1'b1;
          end
          cnt[i] = 40'(c);
        end
      end
      default: ;
    endcase
    r.pending_mask = pend;
    r.irq = |pend;
    expected_q.push_back(r);
  endfunction

  // offer one item and wait for acceptance; valid stays up until the next call decides
  task automatic send_item(action_t act, reg_addr_t addr, logic [7:0] wd,
                           logic [31:0] ncyc);
    while (!calm && $urandom_range(99) < 34) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {4'b0, ncyc, wd, addr, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(act, addr, wd, ncyc);
    items_sent++;
  endtask

  task automatic wait_drain();
    s_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver readiness
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else m_tready <= calm || ($urandom_range(99) >= 34);
  end

  // result checker
  always @(posedge clk) begin
    result_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[16:0]);
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.read_data !== exp_r.read_data) begin
          $error("read_data expected %h actual %h", exp_r.read_data, got.read_data);
          errors++;
        end
        if (got.irq !== exp_r.irq) begin
          $error("irq expected %b actual %b", exp_r.irq, got.irq);
          errors++;
        end
        if (got.pending_mask !== exp_r.pending_mask) begin
          $error("pending_mask expected %h actual %h", exp_r.pending_mask,
                 got.pending_mask);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_register_access();
    send_item(ACT_READ, REG_PENDING, 8'h00, 0);
    send_item(ACT_READ, REG_ENABLE, 8'h00, 0);
    send_item(ACT_READ, REG_RATE_LO, 8'h00, 0);
    send_item(ACT_READ, REG_RATE_HI, 8'h00, 0);
    send_item(ACT_WRITE, REG_RATE_LO, 8'hFF, 0);
    send_item(ACT_WRITE, REG_RATE_HI, 8'hFF, 0);
    send_item(ACT_READ, REG_RATE_LO, 8'h00, 0);
    send_item(ACT_READ, REG_RATE_HI, 8'h00, 0);
    send_item(ACT_NONE, REG_RATE_HI, 8'hA5, 32'hFFFF_FFFF);
  endtask

  task automatic test_firing_and_clear();
    // fastest rate, then zero rate taken as one
    send_item(ACT_WRITE, REG_ENABLE, 8'h01, 0);
    send_item(ACT_TICK, REG_PENDING, 8'h00, 32'd7323);
    send_item(ACT_TICK, REG_PENDING, 8'h00, 32'd1);
    send_item(ACT_WRITE, REG_RATE_LO, 8'h00, 0);
    send_item(ACT_WRITE, REG_RATE_HI, 8'h00, 0);
    send_item(ACT_WRITE, REG_ENABLE, 8'hFF, 0);
    send_item(ACT_READ, REG_ENABLE, 8'h00, 0);
    // catch-up: several intervals in one tick fire once; counters saturate
    send_item(ACT_TICK, REG_PENDING, 8'h00, 32'hFFFF_FFFF);
    send_item(ACT_WRITE, REG_PENDING, 8'h0F, 0);
    send_item(ACT_READ, REG_PENDING, 8'h00, 0);
    for (int k = 0; k < 300; k++)
      send_item(ACT_TICK, REG_PENDING, 8'h00, 32'hFFFF_FFFF);
    send_item(ACT_WRITE, REG_PENDING, 8'hFF, 0);
    send_item(ACT_WRITE, REG_ENABLE, 8'h00, 0);
    send_item(ACT_TICK, REG_PENDING, 8'h00, 32'hFFFF_FFFF);
    send_item(ACT_READ, REG_PENDING, 8'h00, 0);
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int k = 0; k < 20; k++)
      send_item(ACT_READ, reg_addr_t'(k % 4), 8'h00, 0);
    wait_drain();
  endtask

  task automatic test_random_traffic(int n);
    action_t act;
    int pick;
    for (int k = 0; k < n; k++) begin
      calm = (k >= n / 3 && k < n / 2);
      pick = $urandom_range(99);
      if (pick < 40) act = ACT_TICK;
      else if (pick < 70) act = ACT_WRITE;
      else if (pick < 95) act = ACT_READ;
      else act = ACT_NONE;
      send_item(act, reg_addr_t'($urandom_range(3)), 8'($urandom),
                ($urandom_range(3) == 0) ? $urandom
                                         : 32'($urandom_range(2000000)));
    end
    calm = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    pend = 0; ena = 0; rlo = 1; rhi = 0;
    for (int i = 0; i < NTIM; i++) begin
      ival[i] = interval_of(1);
      cnt[i]  = 0;
    end
    test_register_access();
    test_firing_and_clear();
    test_backpressure();
    test_random_traffic(900);
    wait_drain();
    $display("Covered %0d items (reads, writes, ticks, unused action), %0d results checked.",
             items_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0) $display("TEST PASSED");
    else begin
      if (expected_q.size() != 0)
        $error("%0d results never arrived", expected_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
